/* sv/stq_pkg.sv */
// Package for the sorted timeout queue: sizes, operation codes and the
// structs shared by the queue cells and the top level. No dependencies.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int DEPTH   = 16;
    localparam int DELAY_W = 32;
    localparam int TAG_W   = 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_EXPIRE = 1'b1;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic               shift_in;    // insert new entry at its sorted slot
        logic               shift_out;   // pop head, move everything one left
        logic [DELAY_W-1:0] new_delay;
        logic [TAG_W-1:0]   new_tag;
        logic [DELAY_W-1:0] head_delay;  // subtracted from survivors on pop
    } t_cell_ctrl;

    typedef struct packed {
        logic               fired_valid;
        logic [TAG_W-1:0]   fired_tag;
        logic [DELAY_W-1:0] head_delay;
        logic               countdown_enable;
        logic               add_dropped;
        logic               empty_error;
    } t_result;

endpackage

/* sv/stq_ifs.sv */
// Valid/ready channel interfaces for the sorted timeout queue words.
// Depends on stq_pkg for field widths.
`timescale 1ns / 1ps

interface stq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [stq_pkg::DELAY_W-1:0] delay_seconds;
    logic [stq_pkg::TAG_W-1:0]   tag;

    modport source (output valid, output operation, output delay_seconds,
                    output tag, input ready);
    modport sink   (input valid, input operation, input delay_seconds,
                    input tag, output ready);
endinterface

interface stq_out_if;
    logic                        valid;
    logic                        ready;
    logic                        fired_valid;
    logic [stq_pkg::TAG_W-1:0]   fired_tag;
    logic [stq_pkg::DELAY_W-1:0] head_delay;
    logic                        countdown_enable;
    logic                        add_dropped;
    logic                        empty_error;

    modport source (output valid, output fired_valid, output fired_tag,
                    output head_delay, output countdown_enable,
                    output add_dropped, output empty_error, input ready);
    modport sink   (input valid, input fired_valid, input fired_tag,
                    input head_delay, input countdown_enable,
                    input add_dropped, input empty_error, output ready);
endinterface

/* sv/stq_cell.sv */
// One slot of the sorted timeout queue: holds a delay and a tag and trades
// them with its left and right neighbors. Depends on stq_pkg.
`timescale 1ns / 1ps

module stq_cell (
    input  logic                        i_clk,
    input  stq_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_occupied,
    input  logic                        i_left_gt,
    input  logic [stq_pkg::DELAY_W-1:0] i_left_delay,
    input  logic [stq_pkg::TAG_W-1:0]   i_left_tag,
    input  logic [stq_pkg::DELAY_W-1:0] i_right_delay,
    input  logic [stq_pkg::TAG_W-1:0]   i_right_tag,
    output logic [stq_pkg::DELAY_W-1:0] o_delay,
    output logic [stq_pkg::TAG_W-1:0]   o_tag,
    output logic                        o_gt
);

    logic [stq_pkg::DELAY_W-1:0] r_delay, n_delay;
    logic [stq_pkg::TAG_W-1:0]   r_tag, n_tag;

    // This slot holds an entry that the new one must go in front of.
    assign o_gt = i_occupied && (r_delay > i_ctrl.new_delay);

    always_comb begin
        n_delay = r_delay;
        n_tag   = r_tag;
        if (i_ctrl.shift_in) begin
            if (i_left_gt) begin
                n_delay = i_left_delay;
                n_tag   = i_left_tag;
            end else if (o_gt || !i_occupied) begin
                n_delay = i_ctrl.new_delay;
                n_tag   = i_ctrl.new_tag;
            end
        end else if (i_ctrl.shift_out) begin
            n_delay = i_right_delay - i_ctrl.head_delay;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay <= n_delay;
        r_tag   <= n_tag;
    end

    assign o_delay = r_delay;
    assign o_tag   = r_tag;

endmodule

/* sv/sorted_timeout_queue_core.sv */
// Top level of the sorted timeout queue: a chain of stq_cell slots plus the
// fill count and the registered result word. Depends on stq_pkg, stq_ifs, stq_cell.
`timescale 1ns / 1ps

// Sorted timeout queue. Holds up to stq_pkg::DEPTH pending timers, each a
// 32-bit delay and an 8-bit tag, sorted by delay in a chain of cells. An add
// word (operation 0) slides the new timer in behind every entry of equal or
// smaller delay; an expire word (operation 1) pops the head, reports its tag
// and subtracts the head delay from every remaining entry. Each cell decides
// its own move with one compare and one subtract, so the block takes one word
// per clock unless the output stalls; the result word appears in an output
// register in the cycle after acceptance. The input stays ready while that
// register is empty or being drained, so a stalled output holds the queue
// after at most one more word. Every input word produces exactly one result
// word carrying the delay to load into the countdown and its enable. An add
// to a full queue is dropped and flagged; an expire on an empty queue is
// flagged. After reset the queue is empty and ready at once.
module sorted_timeout_queue_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stq_in_if.sink           i_in,
    stq_out_if.source        o_out
);

    localparam int DEPTH = stq_pkg::DEPTH;
    localparam int CNT_W = stq_pkg::CNT_W;

    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    stq_pkg::t_result            r_res, n_res;
    stq_pkg::t_cell_ctrl         w_ctrl;

    logic [stq_pkg::DELAY_W-1:0] w_delay [DEPTH];
    logic [stq_pkg::TAG_W-1:0]   w_tag   [DEPTH];
    logic [DEPTH-1:0]            w_gt;

    logic w_accept, w_is_add, w_full, w_empty, w_do_add, w_do_pop;

    // Take a word whenever the result register is free or drains this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_add   = (i_in.operation == stq_pkg::OP_ADD);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_do_add   = w_accept && w_is_add && !w_full;
    assign w_do_pop   = w_accept && !w_is_add && !w_empty;

    always_comb begin
        w_ctrl.shift_in   = w_do_add;
        w_ctrl.shift_out  = w_do_pop;
        w_ctrl.new_delay  = i_in.delay_seconds;
        w_ctrl.new_tag    = i_in.tag;
        w_ctrl.head_delay = w_delay[0];
    end

    // Chain of slots; occupancy is implied by the fill count.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                        w_left_gt;
        logic [stq_pkg::DELAY_W-1:0] w_left_delay, w_right_delay;
        logic [stq_pkg::TAG_W-1:0]   w_left_tag, w_right_tag;

        if (g == 0) begin : g_first
            assign w_left_gt    = 1'b0;
            assign w_left_delay = w_delay[g];
            assign w_left_tag   = w_tag[g];
        end else begin : g_mid
            assign w_left_gt    = w_gt[g-1];
            assign w_left_delay = w_delay[g-1];
            assign w_left_tag   = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_delay = w_delay[g];
            assign w_right_tag   = w_tag[g];
        end else begin : g_inner
            assign w_right_delay = w_delay[g+1];
            assign w_right_tag   = w_tag[g+1];
        end

        stq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (r_count > CNT_W'(g)),
            .i_left_gt     (w_left_gt),
            .i_left_delay  (w_left_delay),
            .i_left_tag    (w_left_tag),
            .i_right_delay (w_right_delay),
            .i_right_tag   (w_right_tag),
            .o_delay       (w_delay[g]),
            .o_tag         (w_tag[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Advance the fill count and build the result word from the current head.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_do_add) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop) begin
            n_count = r_count - 1'b1;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            if (w_is_add) begin
                n_res.add_dropped      = w_full;
                n_res.countdown_enable = 1'b1;
                // The new timer becomes the head if it beats the current one.
                if (!w_full && (w_empty || w_gt[0])) begin
                    n_res.head_delay = i_in.delay_seconds;
                end else begin
                    n_res.head_delay = w_delay[0];
                end
            end else if (w_empty) begin
                n_res.empty_error = 1'b1;
            end else begin
                n_res.fired_valid      = 1'b1;
                n_res.fired_tag        = w_tag[0];
                n_res.countdown_enable = (r_count > CNT_W'(1));
                if (r_count > CNT_W'(1)) begin
                    n_res.head_delay = w_delay[1] - w_delay[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.fired_valid      = r_res.fired_valid;
    assign o_out.fired_tag        = r_res.fired_tag;
    assign o_out.head_delay       = r_res.head_delay;
    assign o_out.countdown_enable = r_res.countdown_enable;
    assign o_out.add_dropped      = r_res.add_dropped;
    assign o_out.empty_error      = r_res.empty_error;

    // The fill count never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    // Every accepted word yields a result word in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word produced no result");

    // A dropped add leaves the queue untouched.
    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_add && w_full) |=> $stable(r_count))
        else $error("dropped add changed the queue");

    // The countdown enable reported agrees with the fill count left behind.
    a_enable_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_res.countdown_enable == (r_count != '0)))
        else $error("countdown enable disagrees with queue fill");

    // One word never flags both a drop and an empty expire.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.add_dropped && r_res.empty_error))
        else $error("both error flags set");

endmodule

/* test/stq_result_monitor.sv */
// Result monitor for the sorted timeout queue: watches both word channels,
// keeps its own sorted timer list and checks every result word in order.
// Depends on stq_pkg and stq_ifs.
`timescale 1ns / 1ps

module stq_result_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    stq_in_if    i_in,
    stq_out_if   i_out,
    output int   o_error_count,
    output int   o_pending
);

    localparam int DEPTH   = stq_pkg::DEPTH;
    localparam int DELAY_W = stq_pkg::DELAY_W;
    localparam int TAG_W   = stq_pkg::TAG_W;

    logic [DELAY_W-1:0] timer_delay [DEPTH];
    logic [TAG_W-1:0]   timer_tag   [DEPTH];
    int                 timer_count;
    stq_pkg::t_result   due_results [$];
    int                 errors;

    initial begin
        errors        = 0;
        timer_count   = 0;
        o_error_count = 0;
        o_pending     = 0;
    end

    // Apply one accepted word to the timer list and return the result it owes.
    function automatic stq_pkg::t_result advance_timers(input logic op,
                                                        input logic [DELAY_W-1:0] d,
                                                        input logic [TAG_W-1:0] t);
        stq_pkg::t_result   r;
        logic [DELAY_W-1:0] lead;
        int                 slot;
        r = '0;
        if (op == stq_pkg::OP_ADD) begin
            if (timer_count >= DEPTH) begin
                r.add_dropped = 1'b1;
            end else begin
                slot = 0;
                while (slot < timer_count && timer_delay[slot] <= d) slot++;
                for (int k = timer_count; k > slot; k--) begin
                    timer_delay[k] = timer_delay[k-1];
                    timer_tag[k]   = timer_tag[k-1];
                end
                timer_delay[slot] = d;
                timer_tag[slot]   = t;
                timer_count++;
            end
        end else if (timer_count == 0) begin
            r.empty_error = 1'b1;
        end else begin
            lead          = timer_delay[0];
            r.fired_valid = 1'b1;
            r.fired_tag   = timer_tag[0];
            for (int k = 1; k < timer_count; k++) begin
                timer_delay[k-1] = timer_delay[k] - lead;
                timer_tag[k-1]   = timer_tag[k];
            end
            timer_count--;
        end
        if (timer_count > 0) begin
            r.head_delay       = timer_delay[0];
            r.countdown_enable = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DELAY_W-1:0] got,
                                   input logic [DELAY_W-1:0] want);
        $display("%0t stq_result_monitor: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : watch
        stq_pkg::t_result got;
        stq_pkg::t_result want;
        if (!i_rst_n) begin
            timer_count = 0;
            due_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.fired_valid, i_out.fired_tag, i_out.head_delay,
                        i_out.countdown_enable, i_out.add_dropped, i_out.empty_error};
                if (due_results.size() == 0) begin
                    report_mismatch("word with nothing due", got.head_delay, '0);
                end else begin
                    want = due_results.pop_front();
                    if (got.fired_valid !== want.fired_valid)
                        report_mismatch("fired_valid", DELAY_W'(got.fired_valid),
                                        DELAY_W'(want.fired_valid));
                    if (got.fired_tag !== want.fired_tag)
                        report_mismatch("fired_tag", DELAY_W'(got.fired_tag),
                                        DELAY_W'(want.fired_tag));
                    if (got.head_delay !== want.head_delay)
                        report_mismatch("head_delay", got.head_delay, want.head_delay);
                    if (got.countdown_enable !== want.countdown_enable)
                        report_mismatch("countdown_enable", DELAY_W'(got.countdown_enable),
                                        DELAY_W'(want.countdown_enable));
                    if (got.add_dropped !== want.add_dropped)
                        report_mismatch("add_dropped", DELAY_W'(got.add_dropped),
                                        DELAY_W'(want.add_dropped));
                    if (got.empty_error !== want.empty_error)
                        report_mismatch("empty_error", DELAY_W'(got.empty_error),
                                        DELAY_W'(want.empty_error));
                end
            end
            if (i_in.valid && i_in.ready)
                due_results.push_back(advance_timers(i_in.operation, i_in.delay_seconds,
                                                     i_in.tag));
        end
        o_error_count <= errors;
        o_pending     <= due_results.size();
    end

endmodule

/* test/tb_top.sv */
// Testbench top for sorted_timeout_queue_core: clock, reset, add/expire word
// stimulus with random gaps and stalls, and the verdict.
// Depends on stq_pkg, stq_ifs, the block and stq_result_monitor.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH   = stq_pkg::DEPTH;
    localparam int DELAY_W = stq_pkg::DELAY_W;
    localparam int TAG_W   = stq_pkg::TAG_W;

    // Slowest run: ~830 words, each with a random gap and stall; the limit takes it many times over.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          RANDOM_WORDS = 800;

    logic i_clk;
    logic i_rst_n;
    int   error_count;
    int   pending;

    // Calm-stretch counters: while nonzero, that side neither gaps nor stalls.
    int unsigned src_calm;
    int unsigned sink_calm;

    stq_in_if  in_ch ();
    stq_out_if out_ch ();

    sorted_timeout_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    stq_result_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Draw the idle cycles before the next word; now and then start a run
    // of back-to-back words so full-rate streaming is covered too.
    function automatic int unsigned draw_wait(inout int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Delays lean toward small values so equal delays and ties are common,
    // with the extremes and values near the top of the range mixed in.
    function automatic logic [DELAY_W-1:0] pick_delay();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return DELAY_W'($urandom_range(0, 15));
        if (roll < 70) return DELAY_W'($urandom);
        if (roll < 80) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return 32'hFFFF_FFF0 + DELAY_W'($urandom_range(0, 15));
    endfunction

    // Present one word, after a random gap, and hold it until accepted.
    // valid stays high across back-to-back words; it only drops for a gap.
    task automatic send_word(input logic op, input logic [DELAY_W-1:0] d,
                             input logic [TAG_W-1:0] t);
        int unsigned gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.delay_seconds <= d;
        in_ch.tag           <= t;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // Result side: stall a random number of cycles per word, then hold
    // ready high until a word is taken.
    initial begin : drain
        int unsigned stall;
        sink_calm     = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        stall = draw_wait(sink_calm);
        forever begin
            repeat (stall) @(posedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            stall = draw_wait(sink_calm);
            if (stall > 0) out_ch.ready <= 1'b0;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        int issued;
        int burst;
        int unsigned add_pct;
        src_calm             = 0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.operation     <= stq_pkg::OP_ADD;
        in_ch.delay_seconds <= '0;
        in_ch.tag           <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: expire on an empty queue first.
        send_word(stq_pkg::OP_EXPIRE, '1, '1);
        // Build a short list: insert at head, extremes, equal delays in order.
        send_word(stq_pkg::OP_ADD, 32'd1000, 8'h01);
        send_word(stq_pkg::OP_ADD, '0, 8'h00);
        send_word(stq_pkg::OP_ADD, '1, 8'hFF);
        send_word(stq_pkg::OP_ADD, 32'd1000, 8'h02);
        send_word(stq_pkg::OP_ADD, 32'd999, 8'h80);
        // Drain it all; the last pop leaves the countdown disabled.
        repeat (5) send_word(stq_pkg::OP_EXPIRE, '0, '0);
        send_word(stq_pkg::OP_EXPIRE, 32'h5555_5555, 8'hAA);
        // Fill to capacity, then one add that must be dropped.
        repeat (DEPTH) send_word(stq_pkg::OP_ADD, pick_delay(),
                                 TAG_W'($urandom_range(0, 255)));
        send_word(stq_pkg::OP_ADD, '0, 8'h7E);
        send_word(stq_pkg::OP_EXPIRE, '0, '0);

        // Random: bursts with a drifting add/expire mix, so the queue swings
        // between empty and full and both edge flags keep showing up.
        issued = 0;
        while (issued < RANDOM_WORDS) begin
            burst = $urandom_range(10, 50);
            case ($urandom_range(0, 3))
                0: add_pct = 20;
                1: add_pct = 50;
                2: add_pct = 80;
                default: add_pct = 95;
            endcase
            repeat (burst) begin
                if ($urandom_range(0, 99) < add_pct)
                    send_word(stq_pkg::OP_ADD, pick_delay(),
                              TAG_W'($urandom_range(0, 255)));
                else
                    send_word(stq_pkg::OP_EXPIRE, DELAY_W'($urandom),
                              TAG_W'($urandom_range(0, 255)));
                issued++;
            end
        end
        in_ch.valid <= 1'b0;

        // Let the last push land in the monitor, drain, then allow stragglers.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (error_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
